/* rtl/logistic_concentration_score_macros.svh */
// Assertion macros shared by the score pipeline.
`ifndef LOGISTIC_CONCENTRATION_SCORE_MACROS_SVH
`define LOGISTIC_CONCENTRATION_SCORE_MACROS_SVH

`ifndef ASSERT_OFF
`define LCS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lcs: implication failed");
`define LCS_ASSERT_DLY(lbl, clk, rst_n, ante, dly, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##dly (cons)) \
    else $error("lcs: delayed implication failed");
`else
`define LCS_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define LCS_ASSERT_DLY(lbl, clk, rst_n, ante, dly, cons)
`endif

`endif

/* rtl/lcs_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package lcs_pkg;

  localparam int FEAT_W       = 24;
  localparam int COUNT_W      = 4;
  localparam int COEF_W       = 22;
  localparam int PROD_W       = FEAT_W + COEF_W;
  localparam int SUM_W        = 50;
  localparam int SCORE_W      = 16;
  localparam int NUM_COEFS    = 10;
  localparam int MIN_FEATURES = 5;
  localparam int MAX_FEATURES_DEF = 10;

  // Weights in Q.16, rounded to nearest.
  localparam logic signed [COEF_W-1:0] COEF_Q16 [NUM_COEFS] = '{
    -22'sd262179, -22'sd92521, -22'sd1033304, 22'sd460778, 22'sd1189854,
    -22'sd242238, 22'sd208477, -22'sd542231, 22'sd150768, 22'sd192892
  };

  // Intercept moved up to Q.32 so it lines up with the products.
  localparam logic signed [SUM_W-1:0] INTERCEPT_Q32 = SUM_W'(64'sd262627 * 64'sd65536);

  typedef struct packed {
    logic signed [FEAT_W-1:0]  band_power_0;
    logic signed [FEAT_W-1:0]  band_power_1;
    logic signed [FEAT_W-1:0]  band_power_2;
    logic signed [FEAT_W-1:0]  band_power_3;
    logic signed [FEAT_W-1:0]  band_power_4;
    logic signed [FEAT_W-1:0]  band_spread_0;
    logic signed [FEAT_W-1:0]  band_spread_1;
    logic signed [FEAT_W-1:0]  band_spread_2;
    logic signed [FEAT_W-1:0]  band_spread_3;
    logic signed [FEAT_W-1:0]  band_spread_4;
    logic [COUNT_W-1:0]        feature_count;
  } in_t;

  typedef struct packed {
    logic [SCORE_W-1:0] concentration;
    logic               status;
  } out_t;

  // Sideband that rides along the pipeline with each item.
  typedef struct packed {
    logic valid;
    logic status;
  } ctl_t;

endpackage

`default_nettype wire

/* rtl/logistic_concentration_score.sv */
// Channel  | Ports                  | Handshake
// ---------+------------------------+----------------------------------------
// input    | start, busy, in_data   | item taken when start && !busy
// result   | out_valid, out_data    | one-cycle strobe, no back-pressure
//
// One item per clock; busy never rises since nothing in the pipe can stall.
// The pipe holds 1 multiply in the lanes, 3 adder-tree levels and
// 3 sigmoid steps (magnitude, piece select, sign fold and rounding).
// Synchronous active-low reset clears only the sideband (valid and status bits) of the pipe.
// The receiver cannot stall: each result shows for exactly one cycle.
`timescale 1ns / 1ps
`default_nettype none
`include "logistic_concentration_score_macros.svh"

module logistic_concentration_score
  import lcs_pkg::*;
#(
  parameter int MAX_FEATURES = MAX_FEATURES_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic start,
  output logic      busy,
  input  wire in_t  in_data,
  output logic      out_valid,
  output out_t      out_data
);

  localparam int LAT = 7;

  logic signed [FEAT_W-1:0] feat [NUM_COEFS];
  logic signed [PROD_W-1:0] prod [MAX_FEATURES];
  logic [COUNT_W-1:0]       n_eff;
  logic                     accept;
  ctl_t                     ctl_nxt;
  ctl_t                     ctl_r;
  ctl_t                     ctl_z;
  logic signed [SUM_W-1:0]  z;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  assign feat[0] = in_data.band_power_0;
  assign feat[1] = in_data.band_power_1;
  assign feat[2] = in_data.band_power_2;
  assign feat[3] = in_data.band_power_3;
  assign feat[4] = in_data.band_power_4;
  assign feat[5] = in_data.band_spread_0;
  assign feat[6] = in_data.band_spread_1;
  assign feat[7] = in_data.band_spread_2;
  assign feat[8] = in_data.band_spread_3;
  assign feat[9] = in_data.band_spread_4;

  // Counts past the lane count saturate.
  assign n_eff = (in_data.feature_count > COUNT_W'(MAX_FEATURES)) ?
                 COUNT_W'(MAX_FEATURES) : in_data.feature_count;

  assign ctl_nxt.valid  = accept;
  assign ctl_nxt.status = (n_eff < COUNT_W'(MIN_FEATURES));

  for (genvar i = 0; i < MAX_FEATURES; i++) begin : g_lane
    lcs_lane #(
      .IDX(i)
    ) u_lane (
      .clk   (clk),
      .feat  (feat[i]),
      .en    (COUNT_W'(i) < n_eff),
      .prod_r(prod[i])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else begin
      ctl_r <= ctl_nxt;
    end
  end

  lcs_merge #(
    .MAX_FEATURES(MAX_FEATURES)
  ) u_merge (
    .clk   (clk),
    .rst_n (rst_n),
    .prod  (prod),
    .ctl_in(ctl_r),
    .z_r   (z),
    .ctl_r (ctl_z)
  );

  lcs_sigmoid u_sigmoid (
    .clk    (clk),
    .rst_n  (rst_n),
    .z      (z),
    .ctl_in (ctl_z),
    .out_r  (out_data),
    .valid_r(out_valid)
  );

  `LCS_ASSERT_DLY(a_item_gives_result, clk, rst_n, accept, LAT, out_valid)
  `LCS_ASSERT_IMP(a_result_had_item, clk, rst_n, out_valid, $past(accept, LAT))
  `LCS_ASSERT_IMP(a_short_is_zero, clk, rst_n, out_valid && out_data.status, out_data.concentration == '0)

endmodule

`default_nettype wire

/* rtl/lcs_lane.sv */
`timescale 1ns / 1ps
`default_nettype none

module lcs_lane
  import lcs_pkg::*;
#(
  parameter int IDX = 0
) (
  input  wire logic                     clk,
  input  wire logic signed [FEAT_W-1:0] feat,
  input  wire logic                     en,
  output logic signed [PROD_W-1:0]      prod_r
);

  logic signed [PROD_W-1:0] prod_nxt;

  // Features past the count drop out of the sum.
  always_comb begin
    if (en) begin
      prod_nxt = PROD_W'(feat) * PROD_W'(COEF_Q16[IDX]);
    end else begin
      prod_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
  end

endmodule

`default_nettype wire

/* rtl/lcs_merge.sv */
`timescale 1ns / 1ps
`default_nettype none

module lcs_merge
  import lcs_pkg::*;
#(
  parameter int MAX_FEATURES = MAX_FEATURES_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic signed [PROD_W-1:0] prod [MAX_FEATURES],
  input  wire ctl_t                     ctl_in,
  output logic signed [SUM_W-1:0]       z_r,
  output ctl_t                          ctl_r
);

  localparam int NP = (MAX_FEATURES + 1) / 2;
  localparam int NQ = (NP + 1) / 2;

  logic signed [SUM_W-1:0] a_nxt [NP];
  logic signed [SUM_W-1:0] a_r   [NP];
  logic signed [SUM_W-1:0] b_nxt [NQ];
  logic signed [SUM_W-1:0] b_r   [NQ];
  logic signed [SUM_W-1:0] z_nxt;
  ctl_t                    ctl_a_r;
  ctl_t                    ctl_b_r;

  // Level one: lane pairs; the intercept joins the first pair.
  for (genvar k = 0; k < NP; k++) begin : g_lvl_a
    logic signed [SUM_W-1:0] hi;
    logic signed [SUM_W-1:0] base;
    if (2 * k + 1 < MAX_FEATURES) begin : g_pair
      assign hi = SUM_W'(prod[2*k+1]);
    end else begin : g_single
      assign hi = '0;
    end
    if (k == 0) begin : g_icpt
      assign base = INTERCEPT_Q32;
    end else begin : g_noicpt
      assign base = '0;
    end
    assign a_nxt[k] = SUM_W'(prod[2*k]) + hi + base;
  end

  for (genvar k = 0; k < NQ; k++) begin : g_lvl_b
    if (2 * k + 1 < NP) begin : g_pair
      assign b_nxt[k] = a_r[2*k] + a_r[2*k+1];
    end else begin : g_single
      assign b_nxt[k] = a_r[2*k];
    end
  end

  always_comb begin
    z_nxt = '0;
    for (int k = 0; k < NQ; k++) begin
      z_nxt = z_nxt + b_r[k];
    end
  end

  always_ff @(posedge clk) begin
    a_r <= a_nxt;
    b_r <= b_nxt;
    z_r <= z_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_a_r <= '0;
      ctl_b_r <= '0;
      ctl_r   <= '0;
    end else begin
      ctl_a_r <= ctl_in;
      ctl_b_r <= ctl_a_r;
      ctl_r   <= ctl_b_r;
    end
  end

endmodule

`default_nettype wire

/* rtl/lcs_sigmoid.sv */
`timescale 1ns / 1ps
`default_nettype none

module lcs_sigmoid
  import lcs_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic signed [SUM_W-1:0] z,
  input  wire ctl_t                    ctl_in,
  output out_t                         out_r,
  output logic                         valid_r
);

  localparam int Y_W = 34;

  localparam logic [SUM_W-1:0] M_SAT = SUM_W'(64'd5 << 32);
  localparam logic [SUM_W-1:0] M_MID = SUM_W'(64'd19 << 29);
  localparam logic [SUM_W-1:0] M_ONE = SUM_W'(64'd1 << 32);
  localparam logic [Y_W-1:0]   ONE_Q32 = Y_W'(64'd1 << 32);
  localparam logic [Y_W-1:0]   OFS_HI  = Y_W'(64'd27 << 27);
  localparam logic [Y_W-1:0]   OFS_MID = Y_W'(64'd5 << 29);
  localparam logic [Y_W-1:0]   OFS_LO  = Y_W'(64'd1 << 31);
  localparam logic [Y_W-1:0]   HALF_LSB = Y_W'(64'h8000);

  logic [SUM_W-1:0] m_nxt;
  logic [SUM_W-1:0] m_r;
  logic             neg_r;
  logic             neg_y_r;
  logic [Y_W-1:0]   y_nxt;
  logic [Y_W-1:0]   y_r;
  logic [Y_W-1:0]   yf;
  logic [Y_W-1:0]   rnd;
  out_t             out_nxt;
  ctl_t             ctl_m_r;
  ctl_t             ctl_y_r;

  assign m_nxt = z[SUM_W-1] ? $unsigned(-z) : $unsigned(z);

  // Piecewise-linear fit on |z|, truncating shifts.
  always_comb begin
    if (m_r >= M_SAT) begin
      y_nxt = ONE_Q32;
    end else if (m_r >= M_MID) begin
      y_nxt = Y_W'(m_r >> 5) + OFS_HI;
    end else if (m_r >= M_ONE) begin
      y_nxt = Y_W'(m_r >> 3) + OFS_MID;
    end else begin
      y_nxt = Y_W'(m_r >> 2) + OFS_LO;
    end
    if (y_nxt > ONE_Q32) begin
      y_nxt = ONE_Q32;
    end
  end

  always_comb begin
    yf  = neg_y_r ? (ONE_Q32 - y_r) : y_r;
    rnd = yf + HALF_LSB;
    out_nxt.status = ctl_y_r.status;
    if (ctl_y_r.status) begin
      out_nxt.concentration = '0;
    end else if (|rnd[Y_W-1:32]) begin
      out_nxt.concentration = '1;
    end else begin
      out_nxt.concentration = rnd[31:16];
    end
  end

  always_ff @(posedge clk) begin
    m_r     <= m_nxt;
    neg_r   <= z[SUM_W-1];
    y_r     <= y_nxt;
    neg_y_r <= neg_r;
    out_r   <= out_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_m_r <= '0;
      ctl_y_r <= '0;
      valid_r <= 1'b0;
    end else begin
      ctl_m_r <= ctl_in;
      ctl_y_r <= ctl_m_r;
      valid_r <= ctl_y_r.valid;
    end
  end

endmodule

`default_nettype wire
